// File: rtl/ffa_pkg.sv
package ffa_pkg;

  localparam int ALLOC_SLOTS_DEF  = 32;
  localparam int OFFSET_BITS_DEF  = 20;
  localparam int HEADER_BYTES_DEF = 4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOT_HELD = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic shift;
    logic restart;
  } ring_ctl_t;

endpackage

// File: rtl/ffa_cell.sv
module ffa_cell #(
  parameter int FW       = 20,
  parameter int PW       = 21,
  parameter bit RST_USED = 1'b0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ffa_pkg::ring_ctl_t ctl,
  input  logic [PW-1:0]     rst_past,
  input  logic [FW+PW:0]    d,
  output logic [FW+PW:0]    q
);
  logic [FW+PW:0] q_r;

  // entry layout: used, first, past
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.restart) begin
      q_r <= {RST_USED, {FW{1'b0}}, rst_past};
    end else if (ctl.shift) begin
      q_r <= d;
    end
  end

  assign q = q_r;
endmodule

// File: rtl/ffa_ring.sv
module ffa_ring #(
  parameter int N         = 33,
  parameter int FW        = 20,
  parameter int PW        = 21,
  parameter bit HEAD_USED = 1'b0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ffa_pkg::ring_ctl_t ctl,
  input  logic [PW-1:0]     rst_past,
  input  logic [FW+PW:0]    tail_d,
  output logic [FW+PW:0]    head_q
);
  logic [FW+PW:0] chain [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_tail
      ffa_cell #(.FW(FW), .PW(PW), .RST_USED((i == 0) ? HEAD_USED : 1'b0)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .rst_past(rst_past),
        .d(tail_d), .q(chain[i])
      );
    end else begin : g_mid
      ffa_cell #(.FW(FW), .PW(PW), .RST_USED((i == 0) ? HEAD_USED : 1'b0)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .rst_past(rst_past),
        .d(chain[i+1]), .q(chain[i])
      );
    end
  end

  assign head_q = chain[0];
endmodule

// File: rtl/first_fit_allocator_coalescing.sv
// First-fit pool allocator with hole coalescing. Holes and allocated blocks
// live in two rings of cells that rotate one entry per cycle while a pass
// runs, each past the compare/update point at its head, so every search is a
// full lap of a ring (HS = ALLOC_SLOTS+1 hole cells). An allocate takes one
// lap to find the lowest fitting hole and one lap to trim it and store the
// block; a failed allocate takes only the first. A free takes a block lap, a
// neighbor search lap and a merge lap, and only the block lap when the offset
// is not allocated. A write to cfg_pool_bytes restarts the pool. One item is
// in work at a time; the finished result sits in an output register.
module first_fit_allocator_coalescing #(
  parameter int ALLOC_SLOTS  = ffa_pkg::ALLOC_SLOTS_DEF,
  parameter int OFFSET_BITS  = ffa_pkg::OFFSET_BITS_DEF,
  parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [OFFSET_BITS:0]                 cfg_pool_bytes,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_operation,
  input  logic [OFFSET_BITS:0]                 in_request_bytes,
  input  logic [OFFSET_BITS-1:0]               in_free_offset,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_status,
  output logic [OFFSET_BITS-1:0]               out_user_offset,
  output logic [OFFSET_BITS:0]                 out_free_bytes,
  output logic [$clog2(ALLOC_SLOTS+2)-1:0]     out_hole_count
);
  import ffa_pkg::*;

  localparam int HS    = ALLOC_SLOTS + 1;
  localparam int FW    = OFFSET_BITS;
  localparam int PW    = OFFSET_BITS + 1;
  localparam int NW    = PW + 1;
  localparam int EW    = FW + PW + 1;
  localparam int CW    = $clog2(HS + 1);
  localparam int BW    = $clog2(ALLOC_SLOTS + 1);
  localparam int CNT_W = $clog2(HS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_A_SCAN = 3'd1;
  localparam logic [2:0] S_A_MOD  = 3'd2;
  localparam logic [2:0] S_F_SCAN = 3'd3;
  localparam logic [2:0] S_F_FIND = 3'd4;
  localparam logic [2:0] S_F_MOD  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  localparam logic [PW-1:0] POOL_MAX = {1'b1, {FW{1'b0}}};
  localparam logic [PW-1:0] POOL_MIN = PW'(8);
  localparam logic [NW-1:0] HDR_N    = NW'(HEADER_BYTES);
  localparam logic [PW-1:0] HDR_P    = PW'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] HOLE_LAST  = CNT_W'(HS - 1);
  localparam logic [CNT_W-1:0] BLOCK_LAST = CNT_W'(ALLOC_SLOTS - 1);
  localparam logic [BW-1:0] BLOCK_FULL = BW'(ALLOC_SLOTS);

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              op_r, op_nxt;
  logic [NW-1:0]     need_r, need_nxt;
  logic [FW-1:0]     off_r, off_nxt;
  logic              hit_r, hit_nxt;
  logic [FW-1:0]     bfirst_r, bfirst_nxt;
  logic [PW-1:0]     bpast_r, bpast_nxt;
  logic              below_r, below_nxt;
  logic              above_r, above_nxt;
  logic [PW-1:0]     above_past_r, above_past_nxt;
  logic              ins_r, ins_nxt;
  logic [PW-1:0]     total_r, total_nxt;
  logic [CW-1:0]     hcnt_r, hcnt_nxt;
  logic [BW-1:0]     bcnt_r, bcnt_nxt;
  logic [1:0]        st_r, st_nxt;
  logic [FW-1:0]     user_r, user_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [FW-1:0]     out_user_r, out_user_nxt;
  logic [PW-1:0]     out_free_r, out_free_nxt;
  logic [CW-1:0]     out_hcnt_r, out_hcnt_nxt;

  ring_ctl_t         hole_ctl, blk_ctl;
  logic [PW-1:0]     rst_past, cfg_clamped;
  logic [EW-1:0]     hole_head, hole_tail, blk_head, blk_tail;
  logic              hh_used, bh_used;
  logic [FW-1:0]     hh_first, bh_first;
  logic [PW-1:0]     hh_past, bh_past;
  logic [NW-1:0]     hh_size, best_end;
  logic [PW-1:0]     bh_user;
  logic              in_acc;

  assign hh_used  = hole_head[EW-1];
  assign hh_first = hole_head[EW-2:PW];
  assign hh_past  = hole_head[PW-1:0];
  assign bh_used  = blk_head[EW-1];
  assign bh_first = blk_head[EW-2:PW];
  assign bh_past  = blk_head[PW-1:0];

  assign hh_size  = NW'(hh_past - {1'b0, hh_first});
  // best hole kept in bfirst_r/bpast_r during an allocate
  assign best_end = {2'b00, bfirst_r} + need_r;
  assign bh_user  = {1'b0, bh_first} + HDR_P;

  always_comb begin
    cfg_clamped = cfg_pool_bytes;
    if (cfg_pool_bytes < POOL_MIN) cfg_clamped = POOL_MIN;
    if (cfg_pool_bytes > POOL_MAX) cfg_clamped = POOL_MAX;
  end

  assign rst_past = !rst_n ? POOL_MAX : cfg_clamped;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  ffa_ring #(.N(HS), .FW(FW), .PW(PW), .HEAD_USED(1'b1)) u_holes (
    .clk(clk), .rst_n(rst_n), .ctl(hole_ctl), .rst_past(rst_past),
    .tail_d(hole_tail), .head_q(hole_head)
  );

  ffa_ring #(.N(ALLOC_SLOTS), .FW(FW), .PW(PW), .HEAD_USED(1'b0)) u_blocks (
    .clk(clk), .rst_n(rst_n), .ctl(blk_ctl), .rst_past(rst_past),
    .tail_d(blk_tail), .head_q(blk_head)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r + CNT_W'(1);
    op_nxt         = op_r;
    need_nxt       = need_r;
    off_nxt        = off_r;
    hit_nxt        = hit_r;
    bfirst_nxt     = bfirst_r;
    bpast_nxt      = bpast_r;
    below_nxt      = below_r;
    above_nxt      = above_r;
    above_past_nxt = above_past_r;
    ins_nxt        = ins_r;
    total_nxt      = total_r;
    hcnt_nxt       = hcnt_r;
    bcnt_nxt       = bcnt_r;
    st_nxt         = st_r;
    user_nxt       = user_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_user_nxt   = out_user_r;
    out_free_nxt   = out_free_r;
    out_hcnt_nxt   = out_hcnt_r;
    hole_ctl       = '{shift: 1'b0, restart: cfg_wr_en};
    blk_ctl        = '{shift: 1'b0, restart: cfg_wr_en};
    hole_tail      = hole_head;
    blk_tail       = blk_head;

    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (cfg_wr_en) begin
          total_nxt = cfg_clamped;
          hcnt_nxt  = CW'(1);
          bcnt_nxt  = '0;
        end
        if (in_acc) begin
          op_nxt   = in_operation;
          need_nxt = {1'b0, in_request_bytes} + HDR_N;
          off_nxt  = in_free_offset;
          hit_nxt  = 1'b0;
          ins_nxt  = 1'b0;
          user_nxt = '0;
          state_nxt = (in_operation == OP_ALLOC) ? S_A_SCAN : S_F_SCAN;
        end
      end

      S_A_SCAN: begin
        hole_ctl.shift = 1'b1;
        if (hh_used && hh_size >= need_r && (!hit_r || hh_first < bfirst_r)) begin
          hit_nxt    = 1'b1;
          bfirst_nxt = hh_first;
          bpast_nxt  = hh_past;
        end
        if (cnt_r == HOLE_LAST) begin
          cnt_nxt = '0;
          if (!hit_nxt) begin
            st_nxt    = ST_NO_FIT;
            state_nxt = S_DONE;
          end else if (bcnt_r == BLOCK_FULL) begin
            st_nxt    = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_A_MOD;
          end
        end
      end

      S_A_MOD: begin
        hole_ctl.shift = 1'b1;
        if (hh_used && hh_first == bfirst_r) begin
          if (best_end[PW-1:0] == bpast_r) hole_tail[EW-1] = 1'b0;
          else hole_tail[EW-2:PW] = best_end[FW-1:0];
        end
        if (cnt_r <= BLOCK_LAST) begin
          blk_ctl.shift = 1'b1;
          if (!bh_used && !ins_r) begin
            blk_tail = {1'b1, bfirst_r, best_end[PW-1:0]};
            ins_nxt  = 1'b1;
          end
        end
        if (cnt_r == HOLE_LAST) begin
          total_nxt = total_r - need_r[PW-1:0];
          if (best_end[PW-1:0] == bpast_r) hcnt_nxt = hcnt_r - CW'(1);
          bcnt_nxt  = bcnt_r + BW'(1);
          user_nxt  = bfirst_r + HDR_P[FW-1:0];
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
        end
      end

      S_F_SCAN: begin
        blk_ctl.shift = 1'b1;
        if (bh_used && !hit_r && bh_user[FW-1:0] == off_r) begin
          blk_tail[EW-1] = 1'b0;
          hit_nxt    = 1'b1;
          bfirst_nxt = bh_first;
          bpast_nxt  = bh_past;
        end
        if (cnt_r == BLOCK_LAST) begin
          cnt_nxt   = '0;
          below_nxt = 1'b0;
          above_nxt = 1'b0;
          if (!hit_nxt) begin
            st_nxt    = ST_NOT_HELD;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_F_FIND;
          end
        end
      end

      S_F_FIND: begin
        hole_ctl.shift = 1'b1;
        if (hh_used && hh_past == {1'b0, bfirst_r}) below_nxt = 1'b1;
        if (hh_used && {1'b0, hh_first} == bpast_r) begin
          above_nxt      = 1'b1;
          above_past_nxt = hh_past;
        end
        if (cnt_r == HOLE_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_F_MOD;
        end
      end

      S_F_MOD: begin
        hole_ctl.shift = 1'b1;
        if (below_r && above_r) begin
          if (hh_used && hh_past == {1'b0, bfirst_r}) hole_tail[PW-1:0] = above_past_r;
          if (hh_used && {1'b0, hh_first} == bpast_r) hole_tail[EW-1] = 1'b0;
        end else if (below_r) begin
          if (hh_used && hh_past == {1'b0, bfirst_r}) hole_tail[PW-1:0] = bpast_r;
        end else if (above_r) begin
          if (hh_used && {1'b0, hh_first} == bpast_r) hole_tail[EW-2:PW] = bfirst_r;
        end else if (!hh_used && !ins_r) begin
          // no neighbor: the block becomes a hole of its own
          hole_tail = {1'b1, bfirst_r, bpast_r};
          ins_nxt   = 1'b1;
        end
        if (cnt_r == HOLE_LAST) begin
          total_nxt = total_r + (bpast_r - {1'b0, bfirst_r});
          if (below_r && above_r) hcnt_nxt = hcnt_r - CW'(1);
          else if (!below_r && !above_r) hcnt_nxt = hcnt_r + CW'(1);
          bcnt_nxt  = bcnt_r - BW'(1);
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_user_nxt   = user_r;
          out_free_nxt   = total_r;
          out_hcnt_nxt   = hcnt_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      total_r     <= POOL_MAX;
      hcnt_r      <= CW'(1);
      bcnt_r      <= '0;
      hit_r       <= 1'b0;
      ins_r       <= 1'b0;
      below_r     <= 1'b0;
      above_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
      hcnt_r      <= hcnt_nxt;
      bcnt_r      <= bcnt_nxt;
      hit_r       <= hit_nxt;
      ins_r       <= ins_nxt;
      below_r     <= below_nxt;
      above_r     <= above_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    need_r       <= need_nxt;
    off_r        <= off_nxt;
    bfirst_r     <= bfirst_nxt;
    bpast_r      <= bpast_nxt;
    above_past_r <= above_past_nxt;
    st_r         <= st_nxt;
    user_r       <= user_nxt;
    out_status_r <= out_status_nxt;
    out_user_r   <= out_user_nxt;
    out_free_r   <= out_free_nxt;
    out_hcnt_r   <= out_hcnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_user_offset = out_user_r;
  assign out_free_bytes  = out_free_r;
  assign out_hole_count  = out_hcnt_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted item did not start work");

  a_op_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_SCAN || state_r == S_A_MOD) |-> op_r == OP_ALLOC)
    else $error("allocate pass entered for a free");

  a_hole_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r <= CW'(HS))
    else $error("hole count beyond hole cells");

  a_block_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r <= BLOCK_FULL)
    else $error("block count beyond block cells");

  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r == '0 |-> total_r == '0)
    else $error("free bytes without any hole");
endmodule

// File: test/first_fit_allocator_coalescing_tb.sv
`timescale 1ns / 100ps

module first_fit_allocator_coalescing_tb;
  import ffa_pkg::*;

  localparam int SLOTS = ALLOC_SLOTS_DEF;
  localparam int HOLES = SLOTS + 1;
  localparam int HDR = HEADER_BYTES_DEF;
  localparam logic [20:0] POOL_MAX = 21'd1048576;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] user_offset;
    logic [20:0] free_bytes;
    logic [5:0]  hole_count;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [20:0] cfg_pool_bytes = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = 1'b0;
  logic [20:0] in_request_bytes = '0;
  logic [19:0] in_free_offset = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [19:0] out_user_offset;
  logic [20:0] out_free_bytes;
  logic [5:0]  out_hole_count;

  // predictor state
  logic [20:0] pool_size;
  logic [20:0] hole_lo [HOLES];
  logic [20:0] hole_hi [HOLES];
  bit          hole_live [HOLES];
  logic [20:0] blk_lo [SLOTS];
  logic [20:0] blk_hi [SLOTS];
  bit          blk_live [SLOTS];

  alloc_result_t pending_results[$];
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int status_seen [4];
  int hold_req = 0;
  int hold_left = 0;
  int stall_left = 0;
  bit no_idle = 1'b0;

  first_fit_allocator_coalescing u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_pool_bytes   (cfg_pool_bytes),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_request_bytes (in_request_bytes),
    .in_free_offset   (in_free_offset),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_user_offset  (out_user_offset),
    .out_free_bytes   (out_free_bytes),
    .out_hole_count   (out_hole_count)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  task automatic restart_pool(logic [20:0] value);
    logic [20:0] v;
    v = value;
    if (v < 21'd8) v = 21'd8;
    if (v > POOL_MAX) v = POOL_MAX;
    pool_size = v;
    for (int i = 0; i < HOLES; i++) begin
      hole_live[i] = 0;
      hole_lo[i] = '0;
      hole_hi[i] = '0;
    end
    for (int i = 0; i < SLOTS; i++) begin
      blk_live[i] = 0;
      blk_lo[i] = '0;
      blk_hi[i] = '0;
    end
    hole_live[0] = 1;
    hole_hi[0] = v;
  endtask

  task automatic apply_request(logic op, logic [20:0] req, logic [19:0] off);
    alloc_result_t r;
    logic [21:0] need;
    logic [20:0] start;
    logic [19:0] user;
    int h, b, found, below, above;
    r = '0;
    if (op == OP_ALLOC) begin
      need = {1'b0, req} + 22'(HDR);
      h = -1;
      b = -1;
      for (int i = 0; i < HOLES; i++)
        if (hole_live[i] && {1'b0, hole_hi[i] - hole_lo[i]} >= need &&
            (h < 0 || hole_lo[i] < hole_lo[h]))
          h = i;
      for (int i = SLOTS - 1; i >= 0; i--)
        if (!blk_live[i]) b = i;
      if (h < 0) begin
        r.status = ST_NO_FIT;
      end else if (b < 0) begin
        r.status = ST_FULL;
      end else begin
        start = hole_lo[h];
        blk_live[b] = 1;
        blk_lo[b] = start;
        blk_hi[b] = start + need[20:0];
        if ({1'b0, hole_hi[h] - start} == need) hole_live[h] = 0;
        else hole_lo[h] = start + need[20:0];
        user = start[19:0] + 20'(HDR);
        r.user_offset = user;
      end
    end else begin
      found = -1;
      for (int i = 0; i < SLOTS; i++) begin
        user = blk_lo[i][19:0] + 20'(HDR);
        if (found < 0 && blk_live[i] && user == off) found = i;
      end
      if (found < 0) begin
        r.status = ST_NOT_HELD;
      end else begin
        blk_live[found] = 0;
        below = -1;
        above = -1;
        for (int i = HOLES - 1; i >= 0; i--) begin
          if (hole_live[i] && hole_hi[i] == blk_lo[found]) below = i;
          if (hole_live[i] && hole_lo[i] == blk_hi[found]) above = i;
        end
        if (below >= 0 && above >= 0) begin
          hole_hi[below] = hole_hi[above];
          hole_live[above] = 0;
        end else if (below >= 0) begin
          hole_hi[below] = blk_hi[found];
        end else if (above >= 0) begin
          hole_lo[above] = blk_lo[found];
        end else begin
          for (int i = 0; i < HOLES; i++)
            if (!hole_live[i] && found >= 0) begin
              hole_live[i] = 1;
              hole_lo[i] = blk_lo[found];
              hole_hi[i] = blk_hi[found];
              found = -1;
            end
        end
      end
    end
    for (int i = 0; i < HOLES; i++)
      if (hole_live[i]) begin
        r.free_bytes += hole_hi[i] - hole_lo[i];
        r.hole_count += 6'd1;
      end
    pending_results.push_back(r);
  endtask

  task automatic send_item(logic op, logic [20:0] req, logic [19:0] off);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_operation = op;
    in_request_bytes = req;
    in_free_offset = off;
    do @(posedge clk); while (in_stall);
    apply_request(op, req, off);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_pool(logic [20:0] value);
    wait_drained();
    cfg_wr_en = 1'b1;
    cfg_pool_bytes = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    restart_pool(value);
  endtask

  // random free of a live block, or an allocate if nothing is held
  task automatic free_random_block();
    int idx [$];
    int k;
    logic [19:0] off;
    for (int i = 0; i < SLOTS; i++) if (blk_live[i]) idx.push_back(i);
    if (idx.size() == 0) begin
      send_item(OP_ALLOC, 21'($urandom_range(0, 16)), '0);
    end else begin
      k = idx[$urandom_range(0, idx.size() - 1)];
      off = blk_lo[k][19:0] + 20'(HDR);
      send_item(OP_FREE, 21'($urandom), off);
    end
  endtask

  // receiver side: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      status_seen[out_status]++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: status %0d", out_status);
      end else begin
        want = pending_results.pop_front();
        if (want.status !== out_status || want.user_offset !== out_user_offset ||
            want.free_bytes !== out_free_bytes || want.hole_count !== out_hole_count)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d off %0d free %0d holes %0d, got %0d %0d %0d %0d",
                     want.status, want.user_offset, want.free_bytes, want.hole_count,
                     out_status, out_user_offset, out_free_bytes, out_hole_count);
        end
      end
    end
  end

  task automatic test_tiny_pool();
    write_pool(21'd0);
    send_item(OP_ALLOC, 21'd0, '0);
    send_item(OP_ALLOC, 21'd4, '0);
    send_item(OP_ALLOC, 21'd0, '0);
    send_item(OP_FREE, '0, 20'd4);
    send_item(OP_FREE, '0, 20'd8);
    send_item(OP_FREE, '0, 20'd4);
  endtask

  task automatic test_pool_edges();
    write_pool(21'h1FFFFF);
    send_item(OP_ALLOC, POOL_MAX, '0);
    send_item(OP_ALLOC, 21'd1048568, '0);
    // zero-byte block ending at the top wraps its user offset to zero
    send_item(OP_ALLOC, 21'd0, '0);
    send_item(OP_FREE, '0, 20'd0);
    send_item(OP_FREE, '0, 20'hFFFFF);
    write_pool(21'd7);
    send_item(OP_ALLOC, 21'd4, '0);
  endtask

  task automatic test_table_full();
    write_pool(POOL_MAX);
    repeat (SLOTS) send_item(OP_ALLOC, 21'd0, '0);
    send_item(OP_ALLOC, 21'd0, '0);
    send_item(OP_ALLOC, 21'h1FFFFF, '0);
  endtask

  task automatic test_coalesce();
    write_pool(21'd1024);
    repeat (4) send_item(OP_ALLOC, 21'd12, '0);
    send_item(OP_FREE, '0, 20'd20);
    send_item(OP_FREE, '0, 20'd4);
    send_item(OP_FREE, '0, 20'd36);
    send_item(OP_FREE, '0, 20'd52);
    send_item(OP_FREE, '0, 20'd52);
  endtask

  task automatic test_backpressure();
    write_pool(21'd4096);
    hold_req = 400;
    repeat (6) send_item(OP_ALLOC, 21'($urandom_range(0, 64)), '0);
    repeat (4) free_random_block();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [20:0] req;
    int held;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_pool(POOL_MAX);
        1: write_pool(21'($urandom));
        2: write_pool(21'd8);
        default: write_pool(21'($urandom_range(64, 8192)));
      endcase
      no_idle = (phase == 4);
      repeat (100) begin
        held = 0;
        for (int i = 0; i < SLOTS; i++) held += int'(blk_live[i]);
        if ($urandom_range(0, 99) < 8) begin
          send_item(1'($urandom_range(0, 1)), 21'($urandom), 20'($urandom));
        end else if ($urandom_range(0, SLOTS) < held + 4) begin
          free_random_block();
        end else begin
          req = 21'($urandom_range(0, pool_size / 6));
          send_item(OP_ALLOC, req, 20'($urandom));
        end
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    restart_pool(POOL_MAX);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_tiny_pool();
    test_pool_edges();
    test_table_full();
    test_coalesce();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    $display("sent %0d requests over several pool sizes, checked %0d results", items_sent,
             results_seen);
    $display("status mix: ok %0d, no fit %0d, table full %0d, not held %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("first_fit_allocator_coalescing_tb passed");
    else
      $display("first_fit_allocator_coalescing_tb failed");
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("first_fit_allocator_coalescing_tb failed");
    $finish;
  end

endmodule
